[rtl/core/gpll_pkg.sv]
// ----------------------------------------------------------------------------
// gpll_pkg
// shared types, constants and coefficient tables of the grid phase locked loop
// ----------------------------------------------------------------------------
package gpll_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TRIG_W   = 16;
    localparam int PHASE_W  = 32;
    localparam int STEP_W   = 31;
    localparam int GAIN_W   = 24;
    localparam int WIN_W    = 15;
    localparam int CNT_W    = 8;
    localparam int REF_W    = 16;

    localparam int FRAC_S   = TRIG_W - 1;
    localparam int MIX_W    = SAMPLE_W + TRIG_W;
    localparam int Y_W      = 40;
    localparam int E_W      = 38;
    localparam int CHUNK_W  = Y_W / 2;
    localparam int A_W      = 26;
    localparam int PROD_W   = A_W + CHUNK_W + 1;
    localparam int ACC_W    = 72;
    localparam int D_W      = ACC_W - FRAC_S;
    localparam int CX_W     = 34;
    localparam int CZ_W     = 33;

    localparam int CORDIC_STAGES = 18;
    localparam int ITER_W        = 5;
    localparam int CORDIC_K      = 652032874;

    localparam int CF_B0 = 1451;
    localparam int CF_B1 = 2903;
    localparam int CF_A1 = 8167198;
    localparam int CF_A2 = 3978700;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_CENTER   = 3'd0;
    localparam logic [2:0] REG_STEP_HI  = 3'd1;
    localparam logic [2:0] REG_STEP_LO  = 3'd2;
    localparam logic [2:0] REG_PROP     = 3'd3;
    localparam logic [2:0] REG_INTEG    = 3'd4;
    localparam logic [2:0] REG_WINDOW   = 3'd5;
    localparam logic [2:0] REG_CNT_LIM  = 3'd6;
    localparam logic [2:0] REG_ERR_REF  = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] grid_sample;
        logic                       clear_lock;
    } sample_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sine_out;
        logic signed [TRIG_W-1:0] cosine_out;
        logic [PHASE_W-1:0]       phase_out;
        logic [STEP_W-1:0]        phase_step_out;
        logic                     zero_cross;
        logic                     locked;
    } result_t;

    typedef struct packed {
        logic [STEP_W-1:0]       center_step;
        logic [STEP_W-1:0]       step_high_limit;
        logic [STEP_W-1:0]       step_low_limit;
        logic [GAIN_W-1:0]       prop_gain;
        logic [GAIN_W-1:0]       integ_gain;
        logic [WIN_W-1:0]        lock_window;
        logic [CNT_W-1:0]        lock_count_limit;
        logic signed [REF_W-1:0] error_reference;
    } cfg_t;

    typedef enum logic [2:0] {
        A_SAMPLE, A_B0, A_B1, A_A1, A_A2, A_KPI, A_KP
    } a_sel_t;

    typedef enum logic [2:0] {
        B_COS, B_X0, B_X1, B_X2, B_Y1, B_Y2, B_E, B_EOLD
    } b_sel_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_LATCH, DP_SHIFT, DP_SAVE_Y, DP_LOCK, DP_EPREP, DP_PI_D,
        DP_PI_UPD, DP_STEP_R, DP_STEP_S, DP_STEP_C, DP_PHASE, DP_CINIT,
        DP_CITER, DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic                mul_en;
        a_sel_t              a_sel;
        b_sel_t              b_sel;
        logic                b_hi;
        logic                neg;
        logic                first;
        logic [ITER_W-1:0]   iter;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    function automatic logic signed [CZ_W-1:0] atan_val(input logic [ITER_W-1:0] i);
        logic signed [CZ_W-1:0] v;
        case (i)
            5'd0:    v = 33'sd536870912;
            5'd1:    v = 33'sd316933406;
            5'd2:    v = 33'sd167458907;
            5'd3:    v = 33'sd85004756;
            5'd4:    v = 33'sd42667331;
            5'd5:    v = 33'sd21354465;
            5'd6:    v = 33'sd10679838;
            5'd7:    v = 33'sd5340245;
            5'd8:    v = 33'sd2670163;
            5'd9:    v = 33'sd1335087;
            5'd10:   v = 33'sd667544;
            5'd11:   v = 33'sd333772;
            5'd12:   v = 33'sd166886;
            5'd13:   v = 33'sd83443;
            5'd14:   v = 33'sd41722;
            5'd15:   v = 33'sd20861;
            5'd16:   v = 33'sd10430;
            5'd17:   v = 33'sd5215;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/gpll_regs.sv]
// ----------------------------------------------------------------------------
// gpll_regs
// apb register file holding the loop configuration
// ----------------------------------------------------------------------------
module gpll_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gpll_pkg::ADDR_W-1:0] paddr,
    input  logic [gpll_pkg::DATA_W-1:0] pwdata,
    output logic [gpll_pkg::DATA_W-1:0] prdata,
    output gpll_pkg::cfg_t              cfg
);
    import gpll_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign wr_en = psel & penable & pwrite;
    assign idx   = paddr[4:2];
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_step      <= 31'd11811160;
            cfg_reg.step_high_limit  <= 31'd14817637;
            cfg_reg.step_low_limit   <= 31'd9126806;
            cfg_reg.prop_gain        <= 24'd273432;
            cfg_reg.integ_gain       <= 24'd137;
            cfg_reg.lock_window      <= 15'd1280;
            cfg_reg.lock_count_limit <= 8'd200;
            cfg_reg.error_reference  <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CENTER:  cfg_reg.center_step      <= pwdata[STEP_W-1:0];
                REG_STEP_HI: cfg_reg.step_high_limit  <= pwdata[STEP_W-1:0];
                REG_STEP_LO: cfg_reg.step_low_limit   <= pwdata[STEP_W-1:0];
                REG_PROP:    cfg_reg.prop_gain        <= pwdata[GAIN_W-1:0];
                REG_INTEG:   cfg_reg.integ_gain       <= pwdata[GAIN_W-1:0];
                REG_WINDOW:  cfg_reg.lock_window      <= pwdata[WIN_W-1:0];
                REG_CNT_LIM: cfg_reg.lock_count_limit <= pwdata[CNT_W-1:0];
                REG_ERR_REF: cfg_reg.error_reference  <= pwdata[REF_W-1:0];
                default:     cfg_reg.center_step      <= cfg_reg.center_step;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CENTER:  prdata = {1'b0, cfg_reg.center_step};
            REG_STEP_HI: prdata = {1'b0, cfg_reg.step_high_limit};
            REG_STEP_LO: prdata = {1'b0, cfg_reg.step_low_limit};
            REG_PROP:    prdata = {8'b0, cfg_reg.prop_gain};
            REG_INTEG:   prdata = {8'b0, cfg_reg.integ_gain};
            REG_WINDOW:  prdata = {17'b0, cfg_reg.lock_window};
            REG_CNT_LIM: prdata = {24'b0, cfg_reg.lock_count_limit};
            REG_ERR_REF: prdata = {16'b0, cfg_reg.error_reference};
            default:     prdata = '0;
        endcase
    end

endmodule

[rtl/core/gpll_ctrl.sv]
// ----------------------------------------------------------------------------
// gpll_ctrl
// sequencer that steps the datapath through mixing, filter, pi, phase, cordic
// ----------------------------------------------------------------------------
module gpll_ctrl #(
    parameter int DECIMATION = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  gpll_pkg::status_t status,
    output gpll_pkg::cmd_t    cmd
);
    import gpll_pkg::*;

    localparam int TCW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MIX, ST_MDRAIN, ST_SHIFT, ST_FILT, ST_FDRAIN, ST_FSAVE,
        ST_LOCK, ST_EPREP, ST_PI, ST_PDRAIN, ST_PID, ST_PIUPD, ST_STEPR,
        ST_STEPS, ST_STEPC, ST_PHASE, ST_CINIT, ST_CORD, ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [TCW-1:0]    tick_reg;
    logic [3:0]        cnt_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              accept;
    logic              filt_tick;

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid & sample_ready;
    assign filt_tick    = (tick_reg == TCW'(DECIMATION - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg  <= '0;
            cnt_reg   <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        tick_reg  <= filt_tick ? '0 : tick_reg + 1'b1;
                        state_reg <= filt_tick ? ST_MIX : ST_EPREP;
                    end
                end
                ST_MIX:
                begin
                    cnt_reg <= (cnt_reg == 4'd1) ? '0 : cnt_reg + 1'b1;
                    if (cnt_reg == 4'd1)
                        state_reg <= ST_MDRAIN;
                end
                ST_MDRAIN: state_reg <= ST_SHIFT;
                ST_SHIFT:  state_reg <= ST_FILT;
                ST_FILT:
                begin
                    cnt_reg <= (cnt_reg == 4'd9) ? '0 : cnt_reg + 1'b1;
                    if (cnt_reg == 4'd9)
                        state_reg <= ST_FDRAIN;
                end
                ST_FDRAIN: state_reg <= ST_FSAVE;
                ST_FSAVE:  state_reg <= ST_LOCK;
                ST_LOCK:   state_reg <= ST_EPREP;
                ST_EPREP:  state_reg <= ST_PI;
                ST_PI:
                begin
                    cnt_reg <= (cnt_reg == 4'd3) ? '0 : cnt_reg + 1'b1;
                    if (cnt_reg == 4'd3)
                        state_reg <= ST_PDRAIN;
                end
                ST_PDRAIN: state_reg <= ST_PID;
                ST_PID:    state_reg <= ST_PIUPD;
                ST_PIUPD:  state_reg <= ST_STEPR;
                ST_STEPR:  state_reg <= ST_STEPS;
                ST_STEPS:  state_reg <= ST_STEPC;
                ST_STEPC:  state_reg <= ST_PHASE;
                ST_PHASE:  state_reg <= ST_CINIT;
                ST_CINIT:
                begin
                    iter_reg  <= '0;
                    state_reg <= ST_CORD;
                end
                ST_CORD:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(CORDIC_STAGES - 1))
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!status.out_busy)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.op     = DP_NOP;
        cmd.a_sel  = A_SAMPLE;
        cmd.b_sel  = B_COS;
        cmd.iter   = iter_reg;
        case (state_reg)
            ST_IDLE:   cmd.op = accept ? DP_LATCH : DP_NOP;
            ST_MIX:
            begin
                cmd.mul_en = 1'b1;
                cmd.b_hi   = cnt_reg[0];
                cmd.first  = ~cnt_reg[0];
            end
            ST_SHIFT:  cmd.op = DP_SHIFT;
            ST_FILT:
            begin
                cmd.mul_en = 1'b1;
                cmd.b_hi   = cnt_reg[0];
                cmd.first  = (cnt_reg == 4'd0);
                case (cnt_reg[3:1])
                    3'd0:
                    begin
                        cmd.a_sel = A_B0;
                        cmd.b_sel = B_X0;
                    end
                    3'd1:
                    begin
                        cmd.a_sel = A_B1;
                        cmd.b_sel = B_X1;
                    end
                    3'd2:
                    begin
                        cmd.a_sel = A_B0;
                        cmd.b_sel = B_X2;
                    end
                    3'd3:
                    begin
                        cmd.a_sel = A_A1;
                        cmd.b_sel = B_Y1;
                    end
                    default:
                    begin
                        cmd.a_sel = A_A2;
                        cmd.b_sel = B_Y2;
                        cmd.neg   = 1'b1;
                    end
                endcase
            end
            ST_FSAVE:  cmd.op = DP_SAVE_Y;
            ST_LOCK:   cmd.op = DP_LOCK;
            ST_EPREP:  cmd.op = DP_EPREP;
            ST_PI:
            begin
                cmd.mul_en = 1'b1;
                cmd.b_hi   = cnt_reg[0];
                cmd.first  = (cnt_reg == 4'd0);
                cmd.a_sel  = cnt_reg[1] ? A_KP : A_KPI;
                cmd.b_sel  = cnt_reg[1] ? B_EOLD : B_E;
                cmd.neg    = cnt_reg[1];
            end
            ST_PID:    cmd.op = DP_PI_D;
            ST_PIUPD:  cmd.op = DP_PI_UPD;
            ST_STEPR:  cmd.op = DP_STEP_R;
            ST_STEPS:  cmd.op = DP_STEP_S;
            ST_STEPC:  cmd.op = DP_STEP_C;
            ST_PHASE:  cmd.op = DP_PHASE;
            ST_CINIT:  cmd.op = DP_CINIT;
            ST_CORD:   cmd.op = DP_CITER;
            ST_FINISH: cmd.op = status.out_busy ? DP_NOP : DP_OUT;
            default:   cmd.op = DP_NOP;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !sample_ready)
        else $error("sequencer still ready after taking a word");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= TCW'(DECIMATION - 1))
        else $error("decimation counter out of range");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORD) |-> (iter_reg < ITER_W'(CORDIC_STAGES)))
        else $error("cordic iteration count overran");
`endif

endmodule

[rtl/core/gpll_dp.sv]
// ----------------------------------------------------------------------------
// gpll_dp
// datapath: shared multiply-accumulate, filter and pi state, phase, cordic
// ----------------------------------------------------------------------------
module gpll_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  gpll_pkg::cmd_t    cmd,
    output gpll_pkg::status_t status,
    input  gpll_pkg::cfg_t    cfg,
    input  gpll_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output gpll_pkg::result_t result
);
    import gpll_pkg::*;

    // loop state
    logic signed [MIX_W-1:0]  mix_reg [3];
    logic signed [Y_W-1:0]    y_reg [3];
    logic signed [E_W-1:0]    eold_reg;
    logic signed [Y_W-1:0]    pi_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [CNT_W-1:0]         lock_cnt_reg;
    logic                     lock_flag_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    // working registers
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       pv_reg;
    logic                       phi_reg;
    logic                       pneg_reg;
    logic                       pfirst_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [E_W-1:0]      e_reg;
    logic [GAIN_W:0]            kpi_reg;
    logic signed [D_W-1:0]      d_reg;
    logic signed [32:0]         r_reg;
    logic signed [33:0]         s_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       wrap_reg;
    logic signed [CX_W-1:0]     x_reg;
    logic signed [CX_W-1:0]     cy_reg;
    logic signed [CZ_W-1:0]     z_reg;
    logic                       flip_reg;

    logic signed [A_W-1:0]       a_op;
    logic signed [Y_W-1:0]       b_full;
    logic signed [CHUNK_W:0]     b_chunk;
    logic signed [PROD_W-1:0]    prod_c;
    logic signed [ACC_W-1:0]     term_ext;
    logic signed [ACC_W-1:0]     term;
    logic signed [ACC_W-1:0]     yround;
    logic signed [ACC_W-1:0]     yshift;
    logic signed [Y_W-1:0]       ysat;
    logic signed [Y_W:0]         ediff;
    logic signed [Y_W:0]         ysext;
    logic signed [Y_W:0]         win;
    logic                        in_win;
    logic [CNT_W-1:0]            cnt_next;
    logic signed [ACC_W-1:0]     dround;
    logic signed [D_W:0]         psum;
    logic signed [Y_W:0]         pround;
    logic signed [33:0]          hi34;
    logic signed [33:0]          lo34;
    logic signed [33:0]          tclamp;
    logic signed [33:0]          sclamp;
    logic [PHASE_W-1:0]          ptest;
    logic                        flip_c;
    logic [PHASE_W-1:0]          pfold;
    logic signed [CX_W-1:0]      xs;
    logic signed [CX_W-1:0]      ys;
    logic signed [CX_W-1:0]      xf;
    logic signed [CX_W-1:0]      yf;
    logic signed [TRIG_W-1:0]    sin_c;
    logic signed [TRIG_W-1:0]    cos_c;

    function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [CX_W-1:0] v);
        logic signed [CX_W:0] t;
        logic signed [CX_W:0] sh;
        logic signed [TRIG_W-1:0] r;
        t  = (CX_W+1)'(v) + (CX_W+1)'(1 << (FRAC_S - 1));
        sh = t >>> FRAC_S;
        if (sh[CX_W:TRIG_W-1] == '0 || sh[CX_W:TRIG_W-1] == '1)
            r = sh[TRIG_W-1:0];
        else
            r = sh[CX_W] ? {1'b1, {(TRIG_W-1){1'b0}}} : {1'b0, {(TRIG_W-1){1'b1}}};
        return r;
    endfunction

    // operand selection for the shared multiplier
    always_comb
    begin
        case (cmd.a_sel)
            A_SAMPLE: a_op = A_W'(smp_reg);
            A_B0:     a_op = A_W'(CF_B0);
            A_B1:     a_op = A_W'(CF_B1);
            A_A1:     a_op = A_W'(CF_A1);
            A_A2:     a_op = A_W'(CF_A2);
            A_KPI:    a_op = signed'({1'b0, kpi_reg});
            A_KP:     a_op = signed'({2'b0, cfg.prop_gain});
            default:  a_op = '0;
        endcase
        case (cmd.b_sel)
            B_COS:   b_full = Y_W'(cos_reg);
            B_X0:    b_full = Y_W'(mix_reg[0]);
            B_X1:    b_full = Y_W'(mix_reg[1]);
            B_X2:    b_full = Y_W'(mix_reg[2]);
            B_Y1:    b_full = y_reg[1];
            B_Y2:    b_full = y_reg[2];
            B_E:     b_full = Y_W'(e_reg);
            B_EOLD:  b_full = Y_W'(eold_reg);
            default: b_full = '0;
        endcase
        b_chunk = cmd.b_hi ? {b_full[Y_W-1], b_full[Y_W-1:CHUNK_W]}
                           : {1'b0, b_full[CHUNK_W-1:0]};
        prod_c   = a_op * b_chunk;
        term_ext = ACC_W'(prod_reg);
        term     = phi_reg ? (term_ext <<< CHUNK_W) : term_ext;
    end

    // filter output rounding and saturation
    always_comb
    begin
        yround = acc_reg + ACC_W'(64'sd1 <<< 21);
        yshift = yround >>> 22;
        if (yshift[ACC_W-1:Y_W-1] == '0 || yshift[ACC_W-1:Y_W-1] == '1)
            ysat = yshift[Y_W-1:0];
        else
            ysat = yshift[ACC_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
    end

    // lock window test
    always_comb
    begin
        ysext  = (Y_W+1)'(y_reg[0]);
        win    = signed'({{(Y_W-WIN_W-FRAC_S+1){1'b0}}, cfg.lock_window, {FRAC_S{1'b0}}});
        in_win = (ysext < win) && (ysext > -win) && !lock_flag_reg;
        if (in_win)
            cnt_next = (lock_cnt_reg == '1) ? lock_cnt_reg : lock_cnt_reg + 1'b1;
        else
            cnt_next = '0;
    end

    // pi arithmetic
    always_comb
    begin
        ediff  = ysext - ((Y_W+1)'(cfg.error_reference) <<< FRAC_S);
        dround = acc_reg + ACC_W'(64'sd1 <<< (FRAC_S - 1));
        psum   = (D_W+1)'(pi_reg) + (D_W+1)'(d_reg);
        pround = (Y_W+1)'(pi_reg) + (Y_W+1)'(128);
        hi34   = signed'({3'b0, cfg.step_high_limit});
        lo34   = signed'({3'b0, cfg.step_low_limit});
        tclamp = (s_reg > hi34) ? hi34 : s_reg;
        sclamp = (tclamp < lo34) ? lo34 : tclamp;
    end

    // cordic
    always_comb
    begin
        ptest  = phase_reg + 32'h4000_0000;
        flip_c = ptest[PHASE_W-1];
        pfold  = {phase_reg[PHASE_W-1] ^ flip_c, phase_reg[PHASE_W-2:0]};
        xs     = x_reg >>> cmd.iter;
        ys     = cy_reg >>> cmd.iter;
        xf     = flip_reg ? -x_reg : x_reg;
        yf     = flip_reg ? -cy_reg : cy_reg;
        sin_c  = trig_round(yf);
        cos_c  = trig_round(xf);
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_c;
        phi_reg    <= cmd.b_hi;
        pneg_reg   <= cmd.neg;
        pfirst_reg <= cmd.first;
        if (pv_reg)
        begin
            if (pfirst_reg)
                acc_reg <= pneg_reg ? -term : term;
            else
                acc_reg <= pneg_reg ? acc_reg - term : acc_reg + term;
        end
        case (cmd.op)
            DP_LATCH:  smp_reg <= sample.grid_sample;
            DP_EPREP:
            begin
                kpi_reg <= {1'b0, cfg.prop_gain} + {1'b0, cfg.integ_gain};
                if (ediff > 41'sh1F_FFFF_FFFF)
                    e_reg <= 38'sh1F_FFFF_FFFF;
                else if (ediff < -41'sh1F_FFFF_FFFF)
                    e_reg <= -38'sh1F_FFFF_FFFF;
                else
                    e_reg <= ediff[E_W-1:0];
            end
            DP_PI_D:   d_reg <= D_W'(dround >>> FRAC_S);
            DP_STEP_R: r_reg <= 33'(pround >>> 8);
            DP_STEP_S: s_reg <= signed'({3'b0, cfg.center_step}) + 34'(r_reg);
            DP_STEP_C: step_reg <= sclamp[STEP_W-1:0];
            DP_CINIT:
            begin
                z_reg    <= CZ_W'(signed'(pfold));
                x_reg    <= CX_W'(CORDIC_K);
                cy_reg   <= '0;
                flip_reg <= flip_c;
            end
            DP_CITER:
            begin
                if (!z_reg[CZ_W-1])
                begin
                    x_reg  <= x_reg - ys;
                    cy_reg <= cy_reg + xs;
                    z_reg  <= z_reg - atan_val(cmd.iter);
                end
                else
                begin
                    x_reg  <= x_reg + ys;
                    cy_reg <= cy_reg - xs;
                    z_reg  <= z_reg + atan_val(cmd.iter);
                end
            end
            DP_OUT:
            begin
                result_reg.sine_out       <= sin_c;
                result_reg.cosine_out     <= cos_c;
                result_reg.phase_out      <= phase_reg;
                result_reg.phase_step_out <= step_reg;
                result_reg.zero_cross     <= wrap_reg;
                result_reg.locked         <= lock_flag_reg;
            end
            default: ;
        endcase
    end

    // loop state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg           <= 1'b0;
            mix_reg          <= '{default: '0};
            y_reg            <= '{default: '0};
            eold_reg         <= '0;
            pi_reg           <= '0;
            phase_reg        <= '0;
            wrap_reg         <= 1'b0;
            lock_cnt_reg     <= '0;
            lock_flag_reg    <= 1'b0;
            cos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.mul_en;
            // a new word replaces the one taken at this edge
            if (cmd.op == DP_OUT)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            case (cmd.op)
                DP_LATCH:
                begin
                    if (sample.clear_lock)
                    begin
                        lock_flag_reg <= 1'b0;
                        lock_cnt_reg  <= '0;
                    end
                end
                DP_SHIFT:
                begin
                    mix_reg[2] <= mix_reg[1];
                    mix_reg[1] <= mix_reg[0];
                    mix_reg[0] <= acc_reg[MIX_W-1:0];
                    y_reg[2]   <= y_reg[1];
                    y_reg[1]   <= y_reg[0];
                end
                DP_SAVE_Y: y_reg[0] <= ysat;
                DP_LOCK:
                begin
                    lock_cnt_reg <= cnt_next;
                    if (cnt_next > cfg.lock_count_limit)
                        lock_flag_reg <= 1'b1;
                end
                DP_PI_UPD:
                begin
                    eold_reg <= e_reg;
                    if (psum[D_W:Y_W-1] == '0 || psum[D_W:Y_W-1] == '1)
                        pi_reg <= psum[Y_W-1:0];
                    else
                        pi_reg <= psum[D_W] ? {1'b1, {(Y_W-1){1'b0}}}
                                            : {1'b0, {(Y_W-1){1'b1}}};
                end
                DP_PHASE: {wrap_reg, phase_reg} <= {1'b0, phase_reg} + (PHASE_W+1)'(step_reg);
                DP_OUT:   cos_reg <= cos_c;
                default: ;
            endcase
        end
    end

    assign status.out_busy = result_valid_reg & ~result_ready;
    assign result_valid    = result_valid_reg;
    assign result          = result_reg;

`ifndef SYNTHESIS
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_OUT) |-> (!result_valid_reg || result_ready))
        else $error("result register overwritten while word pending");

    a_step_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_STEP_C) |=> (step_reg >= $past(cfg.step_low_limit)))
        else $error("clamped step below low limit");

    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (lock_flag_reg && !(cmd.op == DP_LATCH && sample.clear_lock)) |=> lock_flag_reg)
        else $error("lock flag dropped without clear");
`endif

endmodule

[rtl/core/grid_phase_locked_loop.sv]
// ----------------------------------------------------------------------------
// grid_phase_locked_loop
// single-phase grid pll: mixer, biquad low-pass, pi, phase accumulator, cordic
// ----------------------------------------------------------------------------
// usage
//   sample channel: one word per grid sample (grid_sample, clear_lock),
//   taken when sample_valid and sample_ready are both high
//   result channel: one word per sample (sine, cosine, phase, step,
//   zero crossing, lock), held until result_ready
//   apb port: eight 32-bit registers at byte offsets 0..28; the user must
//   write them only while the loop is idle (not enforced); pready is tied high
// sequence
//   each taken sample runs through the pi, the step clamp, the phase
//   accumulator and the 18 cordic iterations; every DECIMATION-th tick
//   also runs the mixer, the biquad and the lock test first; the shared
//   multiplier is used one partial product per cycle; a new sample is
//   taken only after the previous one has gone through all these steps
//   the result appears in its output register at the end; the next sample
//   is taken while that word still waits, and the sequencer only stalls at
//   its final step when the previous word has not been taken yet
// reset
//   rst_n clears the loop state (histories, pi, phase, lock, last cosine)
//   and loads the register defaults
// ----------------------------------------------------------------------------
module grid_phase_locked_loop #(
    parameter int DECIMATION = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // sample channel
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  gpll_pkg::sample_t           sample,
    // result channel
    output logic                        result_valid,
    input  logic                        result_ready,
    output gpll_pkg::result_t           result,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gpll_pkg::ADDR_W-1:0] paddr,
    input  logic [gpll_pkg::DATA_W-1:0] pwdata,
    output logic [gpll_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import gpll_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // register file, writes complete in the access phase
    assign pready = 1'b1;

    gpll_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sequencer: owns the decimation counter and the step order
    gpll_ctrl #(
        .DECIMATION (DECIMATION)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath: arithmetic, loop state and output register
    gpll_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the grid phase locked loop: a bit-true loop model
// predicts every result word from the accepted sample words, while random
// idling, a long result stall and several register settings exercise the
// mixer, biquad, lock detector, pi, step clamp, phase wrap and cordic
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gpll_pkg::*;

    typedef logic signed [79:0] wide_t;

    localparam longint Y_MAX = 64'sd549755813887;
    localparam longint E_MAX = 64'sd137438953471;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // sample channel
    logic    sample_valid = 1'b0;
    logic    sample_ready;
    sample_t sample = '0;

    // result channel
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // configuration port
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    grid_phase_locked_loop dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // words waiting for the driver, and result words the loop model predicts
    sample_t samples_to_send[$];
    result_t expected_words[$];

    int  failures = 0;
    int  words_seen = 0;
    bit  calm = 1'b0;   // no random idling on either side while set

    // ------------------------------------------------------------------
    // loop model state and register copy
    // ------------------------------------------------------------------
    cfg_t        cfg;
    int          tick;
    longint      mix_hist[3];
    longint      filt_hist[3];
    longint      err_old;
    longint      pi_acc;
    logic [31:0] phase_acc;
    int          lock_cnt;
    bit          lock_flag;
    longint      last_cos;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // round half up from q30 to q1.15 and saturate
    function automatic longint trig_q15(longint v);
        return clip((v + 64'sd16384) >>> 15, -64'sd32768, 64'sd32767);
    endfunction

    function automatic void cordic_sincos(input logic [31:0] p,
                                          output longint s, output longint c);
        logic [31:0] t;
        bit          flip;
        longint      x, y, z, nx;
        t = p + 32'h4000_0000;
        flip = 1'b0;
        // fold into [-1/4, 1/4) turn, undo by negating at the end
        if (t >= 32'h8000_0000)
        begin
            p = p - 32'h8000_0000;
            flip = 1'b1;
        end
        x = CORDIC_K;
        y = 0;
        z = longint'(signed'(p));
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_val(i[ITER_W-1:0]));
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_val(i[ITER_W-1:0]));
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = trig_q15(y);
        c = trig_q15(x);
    endfunction

    function automatic void loop_reset();
        cfg.center_step      = 31'd11811160;
        cfg.step_high_limit  = 31'd14817637;
        cfg.step_low_limit   = 31'd9126806;
        cfg.prop_gain        = 24'd273432;
        cfg.integ_gain       = 24'd137;
        cfg.lock_window      = 15'd1280;
        cfg.lock_count_limit = 8'd200;
        cfg.error_reference  = '0;
        tick = 0;
        mix_hist = '{0, 0, 0};
        filt_hist = '{0, 0, 0};
        err_old = 0;
        pi_acc = 0;
        phase_acc = '0;
        lock_cnt = 0;
        lock_flag = 1'b0;
        last_cos = 0;
    endfunction

    // one sample through the loop: returns the result word it causes
    function automatic result_t pll_predict(sample_t w);
        result_t     r;
        wide_t       acc, yw;
        longint      win, e, d, stepv, s, c;
        logic [32:0] sum;
        if (w.clear_lock)
        begin
            lock_flag = 1'b0;
            lock_cnt = 0;
        end
        tick++;
        // mixer, biquad and lock test on decimated ticks only
        if (tick >= 4)
        begin
            tick = 0;
            win = longint'(cfg.lock_window) <<< 15;
            mix_hist[2] = mix_hist[1];
            mix_hist[1] = mix_hist[0];
            mix_hist[0] = longint'(w.grid_sample) * last_cos;
            filt_hist[2] = filt_hist[1];
            filt_hist[1] = filt_hist[0];
            acc = wide_t'(CF_B0) * wide_t'(mix_hist[0])
                + wide_t'(CF_B1) * wide_t'(mix_hist[1])
                + wide_t'(CF_B0) * wide_t'(mix_hist[2])
                + wide_t'(CF_A1) * wide_t'(filt_hist[1])
                - wide_t'(CF_A2) * wide_t'(filt_hist[2]);
            yw = (acc + (wide_t'(1) <<< 21)) >>> 22;
            if (yw > wide_t'(Y_MAX))
                yw = wide_t'(Y_MAX);
            if (yw < wide_t'(-Y_MAX - 1))
                yw = wide_t'(-Y_MAX - 1);
            filt_hist[0] = longint'(yw);
            if (filt_hist[0] < win && filt_hist[0] > -win && !lock_flag)
            begin
                if (lock_cnt < 255)
                    lock_cnt++;
            end
            else
                lock_cnt = 0;
            if (lock_cnt > int'(cfg.lock_count_limit))
                lock_flag = 1'b1;
        end
        // incremental pi on filter output minus reference
        e = clip(filt_hist[0] - (longint'(cfg.error_reference) <<< 15), -E_MAX, E_MAX);
        d = (longint'(cfg.prop_gain) + longint'(cfg.integ_gain)) * e
          - longint'(cfg.prop_gain) * err_old;
        err_old = e;
        pi_acc = clip(pi_acc + ((d + 64'sd16384) >>> 15), -Y_MAX - 1, Y_MAX);
        // step clamp: high limit first, low limit wins when crossed
        stepv = longint'(cfg.center_step) + ((pi_acc + 128) >>> 8);
        if (stepv > longint'(cfg.step_high_limit))
            stepv = longint'(cfg.step_high_limit);
        if (stepv < longint'(cfg.step_low_limit))
            stepv = longint'(cfg.step_low_limit);
        sum = {1'b0, phase_acc} + 33'(stepv);
        phase_acc = sum[31:0];
        cordic_sincos(phase_acc, s, c);
        last_cos = c;
        r.sine_out       = s[15:0];
        r.cosine_out     = c[15:0];
        r.phase_out      = phase_acc;
        r.phase_step_out = stepv[30:0];
        r.zero_cross     = sum[32];
        r.locked         = lock_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, limit
    // ------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // sample driver: offers the next queued word, idles at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bit holding;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && sample_ready)
                expected_words.push_back(pll_predict(sample));
            holding = sample_valid && !sample_ready;
            if (!holding)
            begin
                if (samples_to_send.size() > 0 && (calm || $urandom_range(99) >= 38))
                begin
                    sample <= samples_to_send.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random ready, one long stall, field by field compare
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int      stall_left;
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                words_seen++;
                // long hold-off so the loop fills up and blocks its input
                if (words_seen == 150)
                    stall_left = 400;
                if (expected_words.size() == 0)
                begin
                    $error("result word with no prediction waiting");
                    failures++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result.sine_out !== want.sine_out)
                    begin
                        $error("sine_out expected %0d actual %0d",
                               want.sine_out, result.sine_out);
                        failures++;
                    end
                    if (result.cosine_out !== want.cosine_out)
                    begin
                        $error("cosine_out expected %0d actual %0d",
                               want.cosine_out, result.cosine_out);
                        failures++;
                    end
                    if (result.phase_out !== want.phase_out)
                    begin
                        $error("phase_out expected %0h actual %0h",
                               want.phase_out, result.phase_out);
                        failures++;
                    end
                    if (result.phase_step_out !== want.phase_step_out)
                    begin
                        $error("phase_step_out expected %0d actual %0d",
                               want.phase_step_out, result.phase_step_out);
                        failures++;
                    end
                    if (result.zero_cross !== want.zero_cross)
                    begin
                        $error("zero_cross expected %0b actual %0b",
                               want.zero_cross, result.zero_cross);
                        failures++;
                    end
                    if (result.locked !== want.locked)
                    begin
                        $error("locked expected %0b actual %0b",
                               want.locked, result.locked);
                        failures++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= calm || $urandom_range(99) >= 38;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    real angle = 0.0;

    // register write: setup cycle, access cycle, model updated at the write edge
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER:  cfg.center_step      = value[30:0];
            REG_STEP_HI: cfg.step_high_limit  = value[30:0];
            REG_STEP_LO: cfg.step_low_limit   = value[30:0];
            REG_PROP:    cfg.prop_gain        = value[23:0];
            REG_INTEG:   cfg.integ_gain       = value[23:0];
            REG_WINDOW:  cfg.lock_window      = value[14:0];
            REG_CNT_LIM: cfg.lock_count_limit = value[7:0];
            REG_ERR_REF: cfg.error_reference  = value[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] cs, hi, lo, kp, ki, win, lim, eref);
        reg_write(REG_CENTER, cs);
        reg_write(REG_STEP_HI, hi);
        reg_write(REG_STEP_LO, lo);
        reg_write(REG_PROP, kp);
        reg_write(REG_INTEG, ki);
        reg_write(REG_WINDOW, win);
        reg_write(REG_CNT_LIM, lim);
        reg_write(REG_ERR_REF, eref);
    endtask

    // half of the words a grid-like sine with random amplitude, the rest small, zero and raw noise
    function automatic sample_t grid_word();
        sample_t w;
        int      roll;
        roll = $urandom_range(99);
        angle = angle + 0.3;
        if (roll < 50)
            w.grid_sample = 16'(int'($urandom_range(32767) * $sin(angle)));
        else if (roll < 70)
            w.grid_sample = 16'(int'($urandom_range(127)) - 64);
        else if (roll < 85)
            w.grid_sample = '0;
        else
            w.grid_sample = 16'($urandom);
        w.clear_lock = $urandom_range(99) < 4;
        return w;
    endfunction

    task automatic queue_random(input int n);
        repeat (n)
            samples_to_send.push_back(grid_word());
    endtask

    task automatic queue_word(input logic signed [15:0] v, input logic clr);
        sample_t w;
        w.grid_sample = v;
        w.clear_lock = clr;
        samples_to_send.push_back(w);
    endtask

    // idle once no word is queued, offered or predicted
    task automatic drain();
        do
            @(negedge clk);
        while (samples_to_send.size() > 0 || sample_valid || expected_words.size() > 0);
    endtask

    initial
    begin
        loop_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: full-scale samples, sign edges, zero, clear requests
        queue_word(16'sd32767, 1'b0);
        queue_word(-16'sd32768, 1'b0);
        queue_word(16'sd0, 1'b1);
        queue_word(-16'sd1, 1'b0);
        queue_word(16'sd1, 1'b0);
        queue_word(16'sd32767, 1'b0);
        queue_word(16'sd32767, 1'b0);
        queue_word(-16'sd32768, 1'b1);
        queue_word(-16'sd32768, 1'b0);
        queue_word(16'sh5555, 1'b0);
        queue_word(16'shAAAA, 1'b0);
        queue_random(50);
        drain();

        // zero count limit and widest window: lock on the first filter tick,
        // then the sticky flag gets cleared by request
        write_all(32'd11811160, 32'd14817637, 32'd9126806, 32'd273432, 32'd137,
                  32'd32767, 32'd0, 32'd0);
        repeat (8) queue_word(16'sd0, 1'b0);
        queue_word(16'sd0, 1'b1);
        repeat (7) queue_word(16'sd0, 1'b0);
        queue_word(16'sd100, 1'b1);
        queue_random(60);
        drain();

        // everything at its top, limit of 255 never locks, step saturates high
        calm = 1'b1;
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFF_FFFF,
                  32'hFF_FFFF, 32'h7FFF, 32'd255, 32'h0000_7FFF);
        queue_random(60);
        drain();
        calm = 1'b0;

        // everything at zero, most negative reference: step stuck at zero
        write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_8000);
        queue_random(50);
        drain();

        // low limit above high limit wins; huge gains with a negative reference
        write_all(32'd11811160, 32'd9000000, 32'd15000000, 32'hFF_FFFF, 32'd4096,
                  32'd1280, 32'd3, 32'hFFFF_FF00);
        queue_random(60);
        drain();

        // fast wrap: large nominal step, wide limits
        write_all(32'h7000_0000, 32'h7FFF_FFFF, 32'd0, 32'd273432, 32'd137,
                  32'd64, 32'd2, 32'd0);
        queue_random(60);
        drain();

        // random settings
        repeat (4)
        begin
            write_all($urandom_range(32'd20000000, 32'd5000000),
                      $urandom_range(32'h7FFF_FFFF, 32'd12000000),
                      $urandom_range(32'd11000000, 32'd0),
                      $urandom_range(32'hFF_FFFF), $urandom_range(32'hFFFF),
                      $urandom_range(32'h7FFF), $urandom_range(32'd10),
                      32'($urandom_range(32'hFFFF)));
            queue_random(35);
            drain();
        end

        repeat (100) @(posedge clk);
        if (failures == 0 && expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[grid_phase_locked_loop.f]
rtl/core/gpll_pkg.sv
rtl/core/gpll_regs.sv
rtl/core/gpll_ctrl.sv
rtl/core/gpll_dp.sv
rtl/core/grid_phase_locked_loop.sv
tb/sv/tb.sv
